[sv/uvs_pkg.sv]
// Shared types, constants and helpers for the UV-sphere cell vertex generator.
// Used by every module of the block; depends on nothing else.
`default_nettype none
package uvs_pkg;

    localparam int LAT_BITS    = 10;
    localparam int LON_BITS    = 10;
    localparam int CNT_BITS    = 11;
    localparam int ANG_BITS    = 16;
    localparam int POS_BITS    = 17;
    localparam int CORNER_BITS = 3;
    localparam int MOD_CELLS   = LON_BITS;
    localparam int HORNER_STEPS = 5;
    localparam int SINCOS_LAT  = HORNER_STEPS + 3;

    localparam logic [CNT_BITS-1:0] MAX_GRID = 11'd1024;
    localparam logic [CORNER_BITS-1:0] CORNER_LAST = 3'd5;
    localparam logic [ANG_BITS-1:0] QUARTER_TURN = 16'h4000;

    typedef enum logic [1:0] {
        CFG_PHI_STEP,
        CFG_THETA_STEP,
        CFG_RADIUS,
        CFG_LON_COUNT
    } t_cfg_idx;

    // Q30 Taylor coefficients of sin(t*pi/2), highest order first.
    localparam logic [31:0] COEF_C11 = 32'd3864;
    localparam logic [31:0] HORNER_COEF [HORNER_STEPS] = '{
        32'd172272, 32'd5026995, 32'd85569306, 32'd693598668, 32'd1686629713
    };

    // One vertex beat travelling through the modulo chain.
    typedef struct packed {
        logic                   valid;
        logic [LON_BITS-1:0]    rem;
        logic [LON_BITS-1:0]    lon;
        logic [LAT_BITS:0]      lat;
        logic                   use_j1;
        logic [CORNER_BITS-1:0] corner;
    } t_beat;

    // Polynomial evaluation state handed from one Horner step to the next.
    typedef struct packed {
        logic [31:0] acc;
        logic [30:0] sq;
        logic [14:0] t;
        logic [1:0]  quad;
    } t_poly;

    // Rounds a product to Q.8 by magnitude, half away from zero, saturating.
    function automatic logic [POS_BITS-1:0] q8_round(input logic signed [48:0] p,
                                                     input logic wide);
        logic [48:0] mag;
        logic [48:0] rnd;
        logic [15:0] res;
        mag = p[48] ? 49'(-p) : 49'(p);
        rnd = wide ? ((mag + (49'd1 << 29)) >> 30) : ((mag + (49'd1 << 14)) >> 15);
        res = (rnd > 49'd65535) ? 16'hFFFF : rnd[15:0];
        return p[48] ? 17'(-{1'b0, res}) : {1'b0, res};
    endfunction

endpackage
`default_nettype wire

[sv/uv_sphere_cell_vertex_generator.sv]
// UV-sphere cell vertex generator: six vertices, two triangles, per grid cell.
// Throughput: one vertex per cycle, set by the output channel, whose stalls hold the pipeline.
// Reset (synchronous, active low) empties every stage and restores the registers.
// Depends on uvs_pkg, uvs_mod_cell and uvs_sincos.
`default_nettype none
module uv_sphere_cell_vertex_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // Input cells: tdata = lat_index[9:0], lon_index[19:10], zero padding.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,
    // Vertices: tdata = pos_x[16:0], pos_y[33:17], pos_z[50:34], corner[53:51], padding.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,
    output logic        o_m_tlast
);
    import uvs_pkg::*;

    typedef struct packed {
        logic                   valid;
        logic [CORNER_BITS-1:0] corner;
    } t_tag;

    typedef struct packed {
        logic [POS_BITS-1:0]    x;
        logic [POS_BITS-1:0]    y;
        logic [POS_BITS-1:0]    z;
        logic [CORNER_BITS-1:0] corner;
    } t_vtx;

    // Configuration registers.
    logic [15:0]         r_phi_step;
    logic [15:0]         r_theta_step;
    logic [15:0]         r_radius;
    logic [CNT_BITS-1:0] r_lon_count;
    logic [CNT_BITS-1:0] w_lc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phi_step   <= '0;
            r_theta_step <= '0;
            r_radius     <= 16'd256;
            r_lon_count  <= 11'd1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PHI_STEP:   r_phi_step   <= i_cfg_data;
                CFG_THETA_STEP: r_theta_step <= i_cfg_data;
                CFG_RADIUS:     r_radius     <= i_cfg_data;
                CFG_LON_COUNT:  r_lon_count  <= i_cfg_data[CNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // A zero count behaves as one column, and counts above the grid are clamped.
    always_comb begin
        priority if (r_lon_count == '0) begin
            w_lc = 11'd1;
        end else if (r_lon_count > MAX_GRID) begin
            w_lc = MAX_GRID;
        end else begin
            w_lc = r_lon_count;
        end
    end

    // The whole pipeline moves together; it holds only when the skid slot is in use.
    logic r_s_valid;
    logic w_adv;
    logic w_accept;

    assign w_adv = !r_s_valid;

    // Expander: holds one accepted cell and issues its six corners, one per cycle while the pipeline advances.
    // A new cell is taken in the same cycle as the sixth corner of the previous one.
    logic                   r_h_valid;
    logic [LAT_BITS-1:0]    r_h_lat;
    logic [LON_BITS-1:0]    r_h_lon;
    logic [CORNER_BITS-1:0] r_h_beat;
    t_beat                  w_head;

    assign o_s_tready = w_adv && (!r_h_valid || r_h_beat == CORNER_LAST);
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_valid <= 1'b0;
            r_h_beat  <= '0;
        end else if (w_adv) begin
            if (w_accept) begin
                r_h_valid <= 1'b1;
                r_h_beat  <= '0;
                r_h_lat   <= i_s_tdata[LAT_BITS-1:0];
                r_h_lon   <= i_s_tdata[LAT_BITS+LON_BITS-1:LAT_BITS];
            end else if (r_h_valid && r_h_beat == CORNER_LAST) begin
                r_h_valid <= 1'b0;
            end else if (r_h_valid) begin
                r_h_beat <= r_h_beat + 3'd1;
            end
        end
    end

    // Corners two to four sit on the lower latitude row; corners one, four and five
    // sit on the next longitude column.
    always_comb begin
        w_head.valid  = r_h_valid;
        w_head.rem    = '0;
        w_head.lon    = r_h_lon;
        w_head.corner = r_h_beat;
        w_head.lat    = {1'b0, r_h_lat} +
                        ((r_h_beat == 3'd2 || r_h_beat == 3'd3 || r_h_beat == 3'd4)
                         ? 11'd1 : 11'd0);
        w_head.use_j1 = (r_h_beat == 3'd1 || r_h_beat == 3'd4 || r_h_beat == CORNER_LAST);
    end

    // Chain of restoring cells: the longitude index modulo the column count.
    t_beat w_cell [MOD_CELLS+1];

    assign w_cell[0] = w_head;

    for (genvar k = 0; k < MOD_CELLS; k++) begin : g_mod
        uvs_mod_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_div   (w_lc),
            .i_beat  (w_cell[k]),
            .o_beat  (w_cell[k+1])
        );
    end

    // Column select: the next column wraps to zero at the count, closing the seam.
    t_tag                r_j_tag;
    logic [LAT_BITS:0]   r_j_lat;
    logic [LON_BITS-1:0] r_j_lon;
    logic [LON_BITS:0]   w_next;
    logic [LON_BITS-1:0] w_j1;

    assign w_next = {1'b0, w_cell[MOD_CELLS].rem} + 11'd1;
    assign w_j1   = (w_next == w_lc) ? '0 : w_next[LON_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j_tag.valid <= 1'b0;
        end else if (w_adv) begin
            r_j_tag.valid  <= w_cell[MOD_CELLS].valid;
            r_j_tag.corner <= w_cell[MOD_CELLS].corner;
            r_j_lat        <= w_cell[MOD_CELLS].lat;
            r_j_lon        <= w_cell[MOD_CELLS].use_j1 ? w_j1 : w_cell[MOD_CELLS].rem;
        end
    end

    // Angles in turns, wrapping modulo a full turn.
    t_tag                r_a_tag;
    logic [ANG_BITS-1:0] r_phi;
    logic [ANG_BITS-1:0] r_theta;
    logic [26:0]         w_phi_prod;
    logic [25:0]         w_theta_prod;

    assign w_phi_prod   = 27'(r_j_lat) * 27'(r_phi_step);
    assign w_theta_prod = 26'(r_j_lon) * 26'(r_theta_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_tag.valid <= 1'b0;
        end else if (w_adv) begin
            r_a_tag <= r_j_tag;
            r_phi   <= w_phi_prod[ANG_BITS-1:0];
            r_theta <= w_theta_prod[ANG_BITS-1:0];
        end
    end

    // Four sine pipelines; cosine is the sine a quarter turn further on.
    logic signed [15:0] w_sp;
    logic signed [15:0] w_cp;
    logic signed [15:0] w_st;
    logic signed [15:0] w_ct;

    uvs_sincos u_sin_phi (
        .i_clk (i_clk), .i_en (w_adv), .i_angle (r_phi), .o_value (w_sp));
    uvs_sincos u_cos_phi (
        .i_clk (i_clk), .i_en (w_adv), .i_angle (r_phi + QUARTER_TURN), .o_value (w_cp));
    uvs_sincos u_sin_theta (
        .i_clk (i_clk), .i_en (w_adv), .i_angle (r_theta), .o_value (w_st));
    uvs_sincos u_cos_theta (
        .i_clk (i_clk), .i_en (w_adv), .i_angle (r_theta + QUARTER_TURN), .o_value (w_ct));

    // Tag line running beside the sine pipelines.
    t_tag r_tag [SINCOS_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SINCOS_LAT; k++) begin
                r_tag[k].valid <= 1'b0;
            end
        end else if (w_adv) begin
            r_tag[0] <= r_a_tag;
            for (int k = 1; k < SINCOS_LAT; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    // First products: radius times sin(phi) and radius times cos(phi).
    t_tag               r_v1_tag;
    logic signed [32:0] r_rsp;
    logic signed [32:0] r_rcp;
    logic signed [15:0] r_v1_st;
    logic signed [15:0] r_v1_ct;
    logic signed [16:0] w_rad;

    assign w_rad = $signed({1'b0, r_radius});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1_tag.valid <= 1'b0;
        end else if (w_adv) begin
            r_v1_tag <= r_tag[SINCOS_LAT-1];
            r_rsp    <= w_rad * w_sp;
            r_rcp    <= w_rad * w_cp;
            r_v1_st  <= w_st;
            r_v1_ct  <= w_ct;
        end
    end

    // Second products give x and z; y is carried along at full width.
    t_tag               r_v2_tag;
    logic signed [48:0] r_x;
    logic signed [48:0] r_y;
    logic signed [48:0] r_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2_tag.valid <= 1'b0;
        end else if (w_adv) begin
            r_v2_tag <= r_v1_tag;
            r_x      <= r_rsp * r_v1_ct;
            r_z      <= r_rsp * r_v1_st;
            r_y      <= 49'(r_rcp);
        end
    end

    t_vtx w_vtx;

    always_comb begin
        w_vtx.x      = q8_round(r_x, 1'b1);
        w_vtx.y      = q8_round(r_y, 1'b0);
        w_vtx.z      = q8_round(r_z, 1'b1);
        w_vtx.corner = r_v2_tag.corner;
    end

    // Output register with a skid slot, so a stalled consumer costs the pipeline
    // nothing until a second vertex is waiting.
    logic r_o_valid;
    t_vtx r_o_data;
    t_vtx r_s_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else if (!r_o_valid || i_m_tready) begin
            if (r_s_valid) begin
                r_o_valid <= 1'b1;
                r_o_data  <= r_s_data;
                r_s_valid <= 1'b0;
            end else begin
                r_o_valid <= r_v2_tag.valid;
                r_o_data  <= w_vtx;
            end
        end else if (w_adv && r_v2_tag.valid) begin
            r_s_valid <= 1'b1;
            r_s_data  <= w_vtx;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {2'b00, r_o_data.corner, r_o_data.z, r_o_data.y, r_o_data.x};
    assign o_m_tlast  = (r_o_data.corner == CORNER_LAST);

`ifndef ASSERT_OFF
    a_skid_behind_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_valid |-> r_o_valid)
        else $error("skid slot holds a vertex while the output register is empty");

    a_accept_loads : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_h_valid && r_h_beat == '0))
        else $error("accepted cell did not start at its first corner");

    a_rem_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cell[MOD_CELLS].valid |-> ({1'b0, w_cell[MOD_CELLS].rem} < w_lc))
        else $error("longitude remainder not below the column count");

    a_no_issue_stalled : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_valid |-> !o_s_tready)
        else $error("input accepted while the pipeline is held");
`endif

endmodule
`default_nettype wire

[sv/uvs_mod_cell.sv]
// One restoring step of the longitude remainder: brings in one index bit.
// Depends on uvs_pkg.
`default_nettype none
module uvs_mod_cell (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic [10:0]             i_div,
    input  uvs_pkg::t_beat          i_beat,
    output uvs_pkg::t_beat          o_beat
);
    import uvs_pkg::*;

    logic [LON_BITS:0] w_part;
    logic [LON_BITS:0] w_diff;
    t_beat             n_beat;
    t_beat             r_beat;

    assign w_part = {i_beat.rem, i_beat.lon[LON_BITS-1]};
    assign w_diff = w_part - i_div;

    always_comb begin
        n_beat     = i_beat;
        n_beat.rem = (w_part >= i_div) ? w_diff[LON_BITS-1:0] : w_part[LON_BITS-1:0];
        n_beat.lon = {i_beat.lon[LON_BITS-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else if (i_en) begin
            r_beat <= n_beat;
        end
    end

    assign o_beat = r_beat;

endmodule
`default_nettype wire

[sv/uvs_horner_cell.sv]
// One Horner step of the sine polynomial: acc = coef - (acc * s) >> 30.
// Depends on uvs_pkg.
`default_nettype none
module uvs_horner_cell (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [31:0]    i_coef,
    input  uvs_pkg::t_poly i_p,
    output uvs_pkg::t_poly o_p
);
    import uvs_pkg::*;

    logic [62:0] w_prod;
    t_poly       n_p;
    t_poly       r_p;

    assign w_prod = 63'(i_p.acc) * 63'(i_p.sq);

    // The square and the angle fields ride along unchanged.
    always_comb begin
        n_p     = i_p;
        n_p.acc = i_coef - w_prod[61:30];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule
`default_nettype wire

[sv/uvs_sincos.sv]
// Pipelined Q1.15 sine of a 16-bit turn angle, built from a chain of Horner cells.
// Depends on uvs_pkg and uvs_horner_cell.
`default_nettype none
module uvs_sincos (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [uvs_pkg::ANG_BITS-1:0]  i_angle,
    output logic signed [15:0]            o_value
);
    import uvs_pkg::*;

    logic [14:0] w_t;
    logic [29:0] w_tt;
    t_poly       r_prep;
    t_poly       w_chain [HORNER_STEPS+1];
    logic [46:0] w_m;
    logic [32:0] r_val;
    logic [1:0]  r_quad;
    logic [33:0] w_rnd;
    logic [15:0] w_mag;
    logic signed [15:0] r_out;

    // Odd quadrants mirror the fraction of the quarter turn.
    assign w_t  = i_angle[14] ? 15'(15'd16384 - {1'b0, i_angle[13:0]})
                              : {1'b0, i_angle[13:0]};
    assign w_tt = 30'(w_t) * 30'(w_t);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prep.acc  <= COEF_C11;
            r_prep.sq   <= {w_tt[28:0], 2'b00};
            r_prep.t    <= w_t;
            r_prep.quad <= i_angle[15:14];
        end
    end

    assign w_chain[0] = r_prep;

    for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_step
        uvs_horner_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_coef (HORNER_COEF[k]),
            .i_p    (w_chain[k]),
            .o_p    (w_chain[k+1])
        );
    end

    assign w_m = 47'(w_chain[HORNER_STEPS].acc) * 47'(w_chain[HORNER_STEPS].t);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val  <= w_m[46:14];
            r_quad <= w_chain[HORNER_STEPS].quad;
        end
    end

    assign w_rnd = 34'(r_val) + 34'd16384;
    assign w_mag = (w_rnd[33:15] > 19'd32767) ? 16'd32767 : w_rnd[30:15];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= r_quad[1] ? $signed(16'(-w_mag)) : $signed(w_mag);
        end
    end

    assign o_value = r_out;

endmodule
`default_nettype wire

[dv/uv_sphere_cell_vertex_generator_test.sv]
// Self-checking testbench for the UV-sphere cell vertex generator.
// Drives grid cells and register writes, predicts the six vertices of each cell
// in fixed point and compares every output transfer. Depends on uvs_pkg and the block.
`default_nettype none
module uv_sphere_cell_vertex_generator_test;
    import uvs_pkg::*;

    // Whole vertex as it leaves the block, tlast included.
    typedef struct packed {
        logic [16:0] x;
        logic [16:0] y;
        logic [16:0] z;
        logic [2:0]  corner;
        logic        last;
    } t_vertex;

    // One directed row: register settings and the cell to send.
    typedef struct {
        logic [15:0] phi;
        logic [15:0] theta;
        logic [15:0] rad;
        logic [10:0] lons;
        logic [9:0]  lat;
        logic [9:0]  lon;
        bit          typed;     // first vertex typed in by hand
        t_vertex     first;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [55:0] o_m_tdata;
    logic        o_m_tlast;

    // Shadow copy of the configuration registers.
    logic [15:0] cur_phi_step;
    logic [15:0] cur_theta_step;
    logic [15:0] cur_radius;
    logic [10:0] cur_lon_count;

    t_vertex     vertex_queue[$];
    int          error_count = 0;
    bit          drain_mode = 1'b0;  // no idling in the last part
    bit          hold_sink = 1'b0;   // long receiver hold-off request

    uv_sphere_cell_vertex_generator u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always #10 i_clk = ~i_clk;

    // Sine of a 32-bit turn angle in Q1.15, by the Q30 odd polynomial.
    function automatic longint sine_q15(input logic [31:0] ang);
        logic [1:0]  quad;
        logic [63:0] frac;
        logic [63:0] t;
        logic [63:0] sq;
        logic [63:0] acc;
        quad = ang[31:30];
        frac = {34'd0, ang[29:0]};
        t = quad[0] ? (64'h4000_0000 - frac) : frac;
        sq = (t * t) >> 30;
        acc = 64'd3864;
        acc = 64'd172272 - ((acc * sq) >> 30);
        acc = 64'd5026995 - ((acc * sq) >> 30);
        acc = 64'd85569306 - ((acc * sq) >> 30);
        acc = 64'd693598668 - ((acc * sq) >> 30);
        acc = 64'd1686629713 - ((acc * sq) >> 30);
        acc = (acc * t) >> 30;
        acc = (acc + 64'd16384) >> 15;
        if (acc > 64'd32767)
            acc = 64'd32767;
        return quad[1] ? -longint'(acc) : longint'(acc);
    endfunction

    // Rounds a signed product to Q.8 by magnitude, half away from zero, saturating.
    function automatic logic [16:0] round_q8(input longint p, input int sh);
        longint mag;
        mag = (p < 0) ? -p : p;
        mag = (mag + (longint'(1) << (sh - 1))) >>> sh;
        if (mag > 65535)
            mag = 65535;
        return (p < 0) ? 17'(-mag) : 17'(mag);
    endfunction

    function automatic t_vertex sphere_point(input logic [10:0] i, input logic [9:0] j,
                                             input logic [2:0] corner);
        logic [31:0] phi;
        logic [31:0] theta;
        longint      sp, cp, st, ct, r;
        t_vertex     v;
        phi = {16'(32'(i) * 32'(cur_phi_step)), 16'd0};
        theta = {16'(32'(j) * 32'(cur_theta_step)), 16'd0};
        sp = sine_q15(phi);
        cp = sine_q15(phi + 32'h4000_0000);
        st = sine_q15(theta);
        ct = sine_q15(theta + 32'h4000_0000);
        r = longint'(cur_radius);
        v.x = round_q8(r * sp * ct, 30);
        v.y = round_q8(r * cp, 15);
        v.z = round_q8(r * sp * st, 30);
        v.corner = corner;
        v.last = (corner == CORNER_LAST);
        return v;
    endfunction

    // Queues the six vertices of one cell, closing the seam at the last longitude.
    task automatic predict_cell_vertices(input logic [9:0] lat, input logic [9:0] lon);
        int          lc;
        logic [10:0] i0, i1;
        logic [9:0]  j0, j1;
        lc = int'(cur_lon_count);
        if (lc == 0)
            lc = 1;
        if (lc > MAX_GRID)
            lc = int'(MAX_GRID);
        i0 = {1'b0, lat};
        i1 = i0 + 11'd1;
        j0 = 10'(int'(lon) % lc);
        j1 = 10'((int'(j0) + 1) % lc);
        vertex_queue.push_back(sphere_point(i0, j0, 3'd0));
        vertex_queue.push_back(sphere_point(i0, j1, 3'd1));
        vertex_queue.push_back(sphere_point(i1, j0, 3'd2));
        vertex_queue.push_back(sphere_point(i1, j0, 3'd3));
        vertex_queue.push_back(sphere_point(i1, j1, 3'd4));
        vertex_queue.push_back(sphere_point(i0, j1, 3'd5));
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_PHI_STEP:   cur_phi_step = value;
            CFG_THETA_STEP: cur_theta_step = value;
            CFG_RADIUS:     cur_radius = value;
            CFG_LON_COUNT:  cur_lon_count = value[10:0];
            default: ;
        endcase
    endtask

    // Waits until every expected vertex has arrived, then for the pipeline depth.
    task automatic wait_until_idle();
        while (vertex_queue.size() != 0)
            @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic set_all(input logic [15:0] phi, input logic [15:0] theta,
                           input logic [15:0] rad, input logic [10:0] lons);
        write_reg(CFG_PHI_STEP, phi);
        write_reg(CFG_THETA_STEP, theta);
        write_reg(CFG_RADIUS, rad);
        write_reg(CFG_LON_COUNT, {5'd0, lons});
    endtask

    // Offers one cell, idling at random beforehand, and holds it until the transfer.
    task automatic send_cell(input logic [9:0] lat, input logic [9:0] lon);
        if (!drain_mode && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {4'd0, lon, lat};
        predict_cell_vertices(lat, lon);
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Receiver: random stalls, plus a long hold-off when asked.
    initial begin
        i_m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_sink) begin
                i_m_tready <= 1'b0;
                repeat (300) @(negedge i_clk);
                hold_sink = 1'b0;
            end else if (!drain_mode && $urandom_range(0, 7) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
        end
    end

    // Output checker: each transfer against the oldest expected vertex.
    always @(posedge i_clk) begin
        t_vertex got;
        t_vertex exp_v;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.x = o_m_tdata[16:0];
            got.y = o_m_tdata[33:17];
            got.z = o_m_tdata[50:34];
            got.corner = o_m_tdata[53:51];
            got.last = o_m_tlast;
            if (vertex_queue.size() == 0) begin
                $display("%0t: unexpected vertex %h", $realtime, got);
                error_count++;
            end else begin
                exp_v = vertex_queue.pop_front();
                if (got !== exp_v) begin
                    $display("%0t: vertex mismatch expected x=%h y=%h z=%h c=%0d l=%b",
                             $realtime, exp_v.x, exp_v.y, exp_v.z, exp_v.corner, exp_v.last);
                    $display("%0t:                 actual   x=%h y=%h z=%h c=%0d l=%b",
                             $realtime, got.x, got.y, got.z, got.corner, got.last);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #(20 * 400000);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        t_row       rows[$];
        t_row       row;
        t_vertex    v;
        logic [9:0] lat, lon;
        int         n;

        cur_phi_step = 16'd0;
        cur_theta_step = 16'd0;
        cur_radius = 16'd256;
        cur_lon_count = 11'd1;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed rows. The typed first vertex is easy to read off by hand:
        // with zero steps every angle is zero, so the point is (0, r, 0), where
        // cos(0) saturates to 32767/32768 and trims the largest radius slightly.
        v = '{x: 17'd0, y: 17'd256, z: 17'd0, corner: 3'd0, last: 1'b0};
        rows.push_back('{16'd0, 16'd0, 16'd256, 11'd1, 10'd0, 10'd0, 1'b1, v});
        v.y = 17'd65533;
        rows.push_back('{16'd0, 16'd0, 16'hFFFF, 11'd1, 10'd1023, 10'd1023, 1'b1, v});
        v.y = 17'd0;
        rows.push_back('{16'd0, 16'd0, 16'd0, 11'd0, 10'd5, 10'd9, 1'b1, v});
        // Quarter-turn latitude step: the first cell starts on the equator, the second at a pole.
        rows.push_back('{16'h4000, 16'h4000, 16'd256, 11'd4, 10'd1, 10'd3, 1'b0, v});
        rows.push_back('{16'h4000, 16'h4000, 16'hFFFF, 11'd4, 10'd2, 10'd7, 1'b0, v});
        // Seam closure at the last longitude and count limits.
        rows.push_back('{16'd1024, 16'd2048, 16'd512, 11'd32, 10'd3, 10'd31, 1'b0, v});
        rows.push_back('{16'd1024, 16'd64, 16'd512, 11'd1024, 10'd1023, 10'd1023, 1'b0, v});
        rows.push_back('{16'd1024, 16'd64, 16'd512, 11'd2047, 10'd1023, 10'd1023, 1'b0, v});
        rows.push_back('{16'd1024, 16'd64, 16'd512, 11'd1025, 10'd0, 10'd1000, 1'b0, v});
        rows.push_back('{16'hFFFF, 16'hFFFF, 16'hFFFF, 11'd0, 10'd1023, 10'd0, 1'b0, v});
        rows.push_back('{16'hFFFF, 16'hFFFF, 16'hFFFF, 11'd1024, 10'd682, 10'd341, 1'b0, v});
        rows.push_back('{16'h2000, 16'h6000, 16'd1, 11'd3, 10'd7, 10'd2, 1'b0, v});
        rows.push_back('{16'h1357, 16'h9ACE, 16'h8000, 11'd17, 10'd100, 10'd16, 1'b0, v});

        foreach (rows[k]) begin
            row = rows[k];
            wait_until_idle();
            set_all(row.phi, row.theta, row.rad, row.lons);
            if (row.typed) begin
                // Hand-typed first vertex; the rest from the predictor.
                send_cell(row.lat, row.lon);
                i_s_tvalid <= 1'b0;
                vertex_queue[vertex_queue.size() - 6] = row.first;
            end else begin
                send_cell(row.lat, row.lon);
                i_s_tvalid <= 1'b0;
            end
        end

        // Random phases, each with fresh register settings.
        for (int phase = 0; phase < 12; phase++) begin
            i_s_tvalid <= 1'b0;
            // Sender pauses until every expected vertex is back.
            wait_until_idle();
            case ($urandom_range(0, 3))
                0: set_all(16'($urandom), 16'($urandom), 16'($urandom),
                           11'($urandom_range(0, 2047)));
                1: set_all(16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)),
                           16'($urandom_range(0, 1024)), 11'($urandom_range(1, 64)));
                2: set_all(16'hFFFF, 16'($urandom), 16'hFFFF, 11'($urandom_range(1, 1024)));
                default: set_all(16'($urandom), 16'h0001, 16'($urandom_range(256, 4096)),
                                 11'($urandom_range(0, 8)));
            endcase
            if (phase == 10)
                drain_mode = 1'b1;
            // A long receiver hold-off while cells keep coming.
            if (phase == 3)
                hold_sink = 1'b1;
            n = 24;
            for (int c = 0; c < n; c++) begin
                lat = 10'($urandom);
                lon = 10'($urandom);
                send_cell(lat, lon);
            end
        end
        i_s_tvalid <= 1'b0;

        fork
            wait_until_idle();
            begin
                repeat (100000) @(negedge i_clk);
            end
        join_any
        disable fork;

        if (error_count == 0 && vertex_queue.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
`default_nettype wire
